// ===== hw/rtl/prqs_pkg.sv =====
// Shared types and constants for the priority ready queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

package prqs_pkg;

  // Field widths of one tick and of one result.
  localparam int unsigned ID_W       = 16;
  localparam int unsigned RT_W       = 16;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned QCOUNT_W   = 5;

  // Default number of ready queue entries.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming tick
    logic insert;  // place the captured job into the ready queue
    logic tick;    // count down, start the next job, load the result register
  } prqs_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prqs_datapath.sv =====
// Datapath: sorted ready queue cells, running job state and result register.
`timescale 1ns / 1ps
`default_nettype none

module prqs_datapath #(
  parameter int unsigned QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire prqs_pkg::prqs_cmd_t       cmd,
  input  wire logic                      arrival_valid,
  input  wire logic [prqs_pkg::ID_W-1:0]   job_id,
  input  wire logic [prqs_pkg::RT_W-1:0]   job_run_time,
  input  wire logic [prqs_pkg::PRIO_W-1:0] job_priority,
  output logic                           done_valid,
  output logic [prqs_pkg::ID_W-1:0]      done_id,
  output logic                           busy_res,
  output logic [prqs_pkg::ID_W-1:0]      running_id,
  output logic [prqs_pkg::QCOUNT_W-1:0]  queue_count,
  output logic                           dropped
);
  import prqs_pkg::*;

  localparam int unsigned LEN_W = $clog2(QUEUE_DEPTH + 1);

  // Captured tick.
  logic              arr_r;
  logic [ID_W-1:0]   id_r;
  logic [RT_W-1:0]   rt_r;
  logic [PRIO_W-1:0] pr_r;

  // Ready queue cells, head at index zero.
  logic [ID_W-1:0]   q_id [QUEUE_DEPTH];
  logic [RT_W-1:0]   q_rt [QUEUE_DEPTH];
  logic [PRIO_W-1:0] q_pr [QUEUE_DEPTH];
  logic [LEN_W-1:0]  len;

  // Running job.
  logic              running;
  logic [RT_W-1:0]   rem;
  logic [ID_W-1:0]   cur_id;
  logic              drop_r;

  logic                   full;
  logic                   do_ins;
  logic [QUEUE_DEPTH-1:0] ins;
  logic                   run_mid;
  logic [RT_W-1:0]        rem_mid;
  logic                   done;
  logic                   start;
  logic                   running_next;
  logic [RT_W-1:0]        rem_next;
  logic [ID_W-1:0]        cur_id_next;
  logic [LEN_W-1:0]       len_after;

  assign full   = (len == LEN_W'(QUEUE_DEPTH));
  assign do_ins = cmd.insert && arr_r && !full;

  // A cell takes part in the insertion when it is empty or less urgent than the new job.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ins[i] = (LEN_W'(i) >= len) || (q_pr[i] > pr_r);
    end
  end

  // One tick of the processor: count down, then an idle processor takes the head.
  always_comb begin
    run_mid = running;
    rem_mid = rem;
    done    = 1'b0;
    if (running) begin
      if (rem <= RT_W'(1)) begin
        run_mid = 1'b0;
        rem_mid = '0;
        done    = 1'b1;
      end else begin
        rem_mid = rem - RT_W'(1);
      end
    end
    start        = !run_mid && (len != '0);
    running_next = run_mid || start;
    rem_next     = start ? q_rt[0] : rem_mid;
    cur_id_next  = start ? q_id[0] : cur_id;
    len_after    = len - LEN_W'(start);
  end

  // Each cell keeps, shifts back behind the new job, takes the new job, or shifts forward on a pop.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (g > 0 && ins[(g > 0) ? g - 1 : 0]) begin
          q_id[g] <= q_id[(g > 0) ? g - 1 : 0];
          q_rt[g] <= q_rt[(g > 0) ? g - 1 : 0];
          q_pr[g] <= q_pr[(g > 0) ? g - 1 : 0];
        end else if (ins[g]) begin
          q_id[g] <= id_r;
          q_rt[g] <= rt_r;
          q_pr[g] <= pr_r;
        end
      end else if (cmd.tick && start && (g < QUEUE_DEPTH - 1)) begin
        q_id[g] <= q_id[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        q_rt[g] <= q_rt[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        q_pr[g] <= q_pr[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  // Input capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r <= arrival_valid;
      id_r  <= job_id;
      rt_r  <= job_run_time;
      pr_r  <= job_priority;
    end
  end

  // Result register, loaded at the end of each tick.
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      done_valid  <= done;
      done_id     <= done ? cur_id : '0;
      busy_res    <= running_next;
      running_id  <= running_next ? cur_id_next : '0;
      queue_count <= QCOUNT_W'(len_after);
      dropped     <= drop_r;
    end
  end

  // Queue length, drop flag and running job state.
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      running <= 1'b0;
      rem     <= '0;
      cur_id  <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.insert) begin
        drop_r <= arr_r && full;
        if (do_ins) begin
          len <= len + LEN_W'(1);
        end
      end
      if (cmd.tick) begin
        running <= running_next;
        rem     <= rem_next;
        cur_id  <= cur_id_next;
        len     <= len_after;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prqs_ctrl.sv =====
// Controller: sequences capture, insertion and the tick, and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module prqs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output prqs_pkg::prqs_cmd_t      cmd
);
  import prqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_TICK
  } state_t;

  state_t state;
  logic   res_free;

  // The result register may be reloaded when empty or when its transfer completes now.
  assign res_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.insert = (state == S_INSERT);
    cmd.tick   = (state == S_TICK) && res_free;
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the tick state the valid flag is set below whenever a transfer completes.
      if (out_valid && !out_stall && (state != S_TICK)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          state <= S_TICK;
        end
        S_TICK: begin
          if (res_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_ready_queue_scheduler.sv =====
// Top level of the non-preemptive priority scheduler with a sorted ready queue.
//
//   channel | direction | handshake            | payload
//   tick    | in        | in_valid / in_stall  | arrival_valid, job_id, job_run_time, job_priority
//   result  | out       | out_valid / out_stall| done_valid, done_id, busy_res, running_id,
//           |           |                      | queue_count, dropped
//
// A tick passes through capture, insertion into the queue cells, and the
// count-down with the pop of the head, which writes the result register.
// The next tick is captured while the previous result still waits to be taken.
// A stalled result holds the tick state until the result register frees up.
// Synchronous reset empties the queue and leaves the processor idle; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          arrival_valid,
  input  wire logic [prqs_pkg::ID_W-1:0]     job_id,
  input  wire logic [prqs_pkg::RT_W-1:0]     job_run_time,
  input  wire logic [prqs_pkg::PRIO_W-1:0]   job_priority,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               done_valid,
  output logic [prqs_pkg::ID_W-1:0]          done_id,
  output logic                               busy_res,
  output logic [prqs_pkg::ID_W-1:0]          running_id,
  output logic [prqs_pkg::QCOUNT_W-1:0]      queue_count,
  output logic                               dropped
);
  import prqs_pkg::*;

  prqs_cmd_t cmd;

  // Sequencer.
  prqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Queue and processor state.
  prqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .arrival_valid (arrival_valid),
    .job_id        (job_id),
    .job_run_time  (job_run_time),
    .job_priority  (job_priority),
    .done_valid    (done_valid),
    .done_id       (done_id),
    .busy_res      (busy_res),
    .running_id    (running_id),
    .queue_count   (queue_count),
    .dropped       (dropped)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/prqs_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module prqs_checker #(
  parameter int unsigned QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          done_valid,
  input wire logic [prqs_pkg::ID_W-1:0]     done_id,
  input wire logic                          busy_res,
  input wire logic [prqs_pkg::ID_W-1:0]     running_id,
  input wire logic [prqs_pkg::QCOUNT_W-1:0] queue_count,
  input wire logic                          dropped
);
  import prqs_pkg::*;

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(done_id) && $stable(running_id)
      && $stable(queue_count) && $stable(done_valid) && $stable(busy_res) && $stable(dropped))
    else $error("stalled result changed");

  // One tick at a time: after a transfer in, the input side stalls.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second tick accepted while one is in work");

  // No finished job means no finished id.
  a_done_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_valid |-> done_id == '0)
    else $error("done_id set without done_valid");

  // An idle processor shows no running id.
  a_run_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> running_id == '0)
    else $error("running_id set while idle");

  // A drop means the queue was full, so the processor cannot stay idle.
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> busy_res)
    else $error("drop reported with idle processor");

endmodule

bind priority_ready_queue_scheduler prqs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_prqs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .done_valid  (done_valid),
  .done_id     (done_id),
  .busy_res    (busy_res),
  .running_id  (running_id),
  .queue_count (queue_count),
  .dropped     (dropped)
);

`default_nettype wire
